// ===== rtl/core/smc_pkg.sv =====
`default_nettype none

package smc_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int BYTE_W      = 8;
   localparam int POS_W       = 32;
   localparam int CNT_W       = 32;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_APPEND  = 2'd1,
      REQ_TEXT    = 2'd2,
      REQ_RESTART = 2'd3
   } req_code_type;

   // Per-cycle strobes broadcast to every cell of the chain.
   typedef struct packed {
      logic clear_pat;
      logic append;
      logic text;
      logic clear_vec;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/smc_cell.sv =====
`default_nettype none

module smc_cell
   import smc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_ctl_type      ctl,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              prev_active,
   input  wire logic              prev_match,
   input  wire logic              next_active,
   output logic                   active,
   output logic                   match,
   output logic                   hit
);

   logic              active_ff;
   logic              active_in;
   logic              match_ff;
   logic              match_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              wr_en;
   logic              match_new;

   // The first inactive cell behind an active one takes the appended byte.
   assign wr_en     = ctl.append & prev_active & ~active_ff;
   assign match_new = prev_match & active_ff & (byte_ff == data_byte);

   always_comb begin
      active_in = active_ff;
      if (ctl.clear_pat) begin
         active_in = 1'b0;
      end else if (wr_en) begin
         active_in = 1'b1;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (ctl.clear_vec) begin
         match_in = 1'b0;
      end else if (ctl.text) begin
         match_in = match_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         match_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         match_ff  <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_ff <= data_byte;
      end
   end

   assign active = active_ff;
   assign match  = match_ff;
   // The last active cell reports that the whole pattern has been seen.
   assign hit    = match_new & ~next_active;

endmodule

`default_nettype wire

// ===== rtl/core/shift_and_string_matcher_core.sv =====
`default_nettype none

// Exact string matcher using the shift-and scheme over a chain of byte cells.
// Input channel (req_*): each word carries a request code, a data byte and a
// start position. Codes clear the pattern, append one pattern byte (refused
// with rsp_status set once 32 bytes are held), feed one text byte, or restart
// the scan at req_start_position, which also zeroes the hit count.
// Result channel (rsp_*): exactly one word per request. For a text byte that
// completes an occurrence, rsp_match_found is set and rsp_match_start gives the
// position of its first byte; rsp_hit_count always shows the saturating count
// of matches since the last restart, including this request.
// rsp_valid rises in the cycle after acceptance. A new word is accepted in
// every cycle while the result register is free: each cell compares its byte
// with the prior cell's registered match bit. The result register frees as
// its word is taken, so req_ready stays high while rsp_ready is high; when
// the receiver stalls, one result is held and req_ready drops until taken.
// Reset empties the pattern and zeroes the match bits, text position and
// hit count; the block is ready in the first cycle after reset.

module shift_and_string_matcher_core
   import smc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_type,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic [POS_W-1:0]  req_start_position,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_status,
   output logic                   rsp_match_found,
   output logic [POS_W-1:0]       rsp_match_start,
   output logic [CNT_W-1:0]       rsp_hit_count
);

   req_code_type            code;
   logic                    fire;
   logic                    full;
   cell_ctl_type            ctl;
   logic [MAX_PATTERN-1:0]  active;
   logic [MAX_PATTERN-1:0]  match;
   logic [MAX_PATTERN-1:0]  hit;
   logic [MAX_PATTERN-1:0]  active_chain;
   logic [MAX_PATTERN-1:0]  match_chain;
   logic [MAX_PATTERN-1:0]  next_chain;
   logic                    found;

   logic [LEN_W-1:0]        length_ff;
   logic [LEN_W-1:0]        length_in;
   logic [POS_W-1:0]        position_ff;
   logic [POS_W-1:0]        position_in;
   logic [CNT_W-1:0]        total_ff;
   logic [CNT_W-1:0]        total_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    status_ff;
   logic                    found_ff;
   logic [POS_W-1:0]        start_ff;
   logic [POS_W-1:0]        start_in;
   logic [CNT_W-1:0]        count_ff;

   assign code      = req_code_type'(req_type);
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign fire      = req_valid & req_ready;
   assign full      = (length_ff >= LEN_W'(MAX_PATTERN));

   always_comb begin
      ctl = '0;
      if (fire) begin
         case (code)
            REQ_CLEAR: begin
               ctl.clear_pat = 1'b1;
               ctl.clear_vec = 1'b1;
            end
            REQ_APPEND: begin
               ctl.append    = ~full;
               ctl.clear_vec = ~full;
            end
            REQ_TEXT: begin
               ctl.text = 1'b1;
            end
            REQ_RESTART: begin
               ctl.clear_vec = 1'b1;
            end
            default: begin
               ctl = '0;
            end
         endcase
      end
   end

   // Cell zero sees an always-active, always-matching neighbor in front of it.
   assign active_chain = {active[MAX_PATTERN-2:0], 1'b1};
   assign match_chain  = {match[MAX_PATTERN-2:0], 1'b1};
   // The last cell has no neighbor behind it.
   assign next_chain   = {1'b0, active[MAX_PATTERN-1:1]};

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      smc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .data_byte   (req_data_byte),
         .prev_active (active_chain[i]),
         .prev_match  (match_chain[i]),
         .next_active (next_chain[i]),
         .active      (active[i]),
         .match       (match[i]),
         .hit         (hit[i])
      );
   end

   assign found = ctl.text & (|hit);

   always_comb begin
      length_in   = length_ff;
      position_in = position_ff;
      total_in    = total_ff;
      if (fire) begin
         case (code)
            REQ_CLEAR: begin
               length_in = '0;
            end
            REQ_APPEND: begin
               if (!full) begin
                  length_in = length_ff + LEN_W'(1);
               end
            end
            REQ_TEXT: begin
               position_in = position_ff + POS_W'(1);
               if (found && (total_ff != {CNT_W{1'b1}})) begin
                  total_in = total_ff + CNT_W'(1);
               end
            end
            REQ_RESTART: begin
               position_in = req_start_position;
               total_in    = '0;
            end
            default: begin
               length_in = length_ff;
            end
         endcase
      end
   end

   assign start_in = found ? (position_ff - POS_W'(length_ff) + POS_W'(1)) : '0;
   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         position_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         position_ff  <= position_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= (code == REQ_APPEND) & full;
         found_ff  <= found;
         start_ff  <= start_in;
         count_ff  <= total_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_found = found_ff;
   assign rsp_match_start = start_ff;
   assign rsp_hit_count   = count_ff;

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond capacity");

   a_active_count: assert property (@(posedge clock) disable iff (reset)
      $countones(active) == 32'(length_ff))
      else $error("active cells disagree with pattern length");

   a_empty_no_match: assert property (@(posedge clock) disable iff (reset)
      found |-> (length_ff != '0))
      else $error("match reported with empty pattern");

   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff |-> !found_ff)
      else $error("rejected append also reports a match");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      fire && (code == REQ_RESTART) |=> (total_ff == '0) && (match == '0))
      else $error("restart left hit count or match bits set");

endmodule

`default_nettype wire

// ===== dv/tb_shift_and_string_matcher_core.sv =====
`default_nettype none

module tb_shift_and_string_matcher_core;
   import smc_pkg::*;

   typedef struct packed {
      logic             status;
      logic             found;
      logic [POS_W-1:0] first_pos;
      logic [CNT_W-1:0] hits;
   } match_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_type = REQ_CLEAR;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic [POS_W-1:0]  req_start_position = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_status;
   logic              rsp_match_found;
   logic [POS_W-1:0]  rsp_match_start;
   logic [CNT_W-1:0]  rsp_hit_count;

   // Mirror of the matcher state.
   logic [BYTE_W-1:0]      pat_mem [MAX_PATTERN];
   int unsigned            pat_len = 0;
   logic [MAX_PATTERN-1:0] run_vec = '0;
   logic [POS_W-1:0]       scan_pos = '0;
   logic [CNT_W-1:0]       hit_total = '0;

   match_report_type match_reports [$];
   int unsigned      mismatch_count = 0;
   int unsigned      sent_count = 0;
   bit               no_gaps = 1'b0;

   shift_and_string_matcher_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_data_byte      (req_data_byte),
      .req_start_position (req_start_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_match_found    (rsp_match_found),
      .rsp_match_start    (rsp_match_start),
      .rsp_hit_count      (rsp_hit_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic match_report_type shift_and_step(req_code_type code,
                                                       logic [BYTE_W-1:0] b,
                                                       logic [POS_W-1:0] sp);
      match_report_type       r;
      logic [MAX_PATTERN-1:0] sel;
      r = '0;
      case (code)
         REQ_CLEAR: begin
            pat_len = 0;
            run_vec = '0;
         end
         REQ_APPEND: begin
            if (pat_len >= MAX_PATTERN) begin
               r.status = 1'b1;
            end else begin
               pat_mem[pat_len] = b;
               pat_len++;
               run_vec = '0;
            end
         end
         REQ_TEXT: begin
            sel = '0;
            for (int i = 0; i < pat_len; i++)
               if (pat_mem[i] == b) sel[i] = 1'b1;
            run_vec = ((run_vec << 1) | 1) & sel;
            if (pat_len > 0 && run_vec[pat_len-1]) begin
               r.found = 1'b1;
               r.first_pos = scan_pos - pat_len + 1;
               if (hit_total != '1) hit_total++;
            end
            scan_pos++;
         end
         default: begin
            scan_pos  = sp;
            run_vec   = '0;
            hit_total = '0;
         end
      endcase
      r.hits = hit_total;
      return r;
   endfunction

   // The request is predicted before the result is checked, so the order holds
   // even if a result were to come back in the cycle of its request.
   always @(posedge clock) begin : monitor
      match_report_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            match_reports.push_back(shift_and_step(req_code_type'(req_type),
                                                   req_data_byte, req_start_position));
         if (rsp_valid && rsp_ready) begin
            if (match_reports.size() == 0) begin
               $error("result word arrived with no request pending");
               mismatch_count++;
            end else begin
               want = match_reports.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_match_found !== want.found) begin
                  $error("rsp_match_found: expected %0d, actual %0d",
                         want.found, rsp_match_found);
                  mismatch_count++;
               end
               if (rsp_match_start !== want.first_pos) begin
                  $error("rsp_match_start: expected %h, actual %h",
                         want.first_pos, rsp_match_start);
                  mismatch_count++;
               end
               if (rsp_hit_count !== want.hits) begin
                  $error("rsp_hit_count: expected %0d, actual %0d", want.hits, rsp_hit_count);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_gaps || ($urandom_range(99) >= 31);
   end

   // Valid is left high after acceptance; it only drops while idling or draining.
   task automatic send_word(req_code_type code, logic [BYTE_W-1:0] b, logic [POS_W-1:0] sp);
      while (!no_gaps && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= code;
      req_data_byte      <= b;
      req_start_position <= sp;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic wait_all_reported();
      req_valid <= 1'b0;
      @(posedge clock);
      while (match_reports.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_pattern();
      send_word(REQ_TEXT, 8'h00, '0);
      send_word(REQ_TEXT, 8'hFF, '1);
   endtask

   task automatic test_two_byte_match();
      send_word(REQ_APPEND, 8'h61, '0);
      send_word(REQ_APPEND, 8'h62, '1);
      send_word(REQ_TEXT, 8'h78, '0);
      send_word(REQ_TEXT, 8'h61, '0);
      send_word(REQ_TEXT, 8'h62, '0);
      send_word(REQ_TEXT, 8'h61, '0);
      send_word(REQ_TEXT, 8'h62, '0);
   endtask

   // A run of equal bytes gives overlapping occurrences; appending then
   // restarts matching on the longer pattern.
   task automatic test_overlap_extremes();
      send_word(REQ_CLEAR, 8'hFF, '1);
      send_word(REQ_APPEND, 8'h00, '0);
      send_word(REQ_APPEND, 8'h00, '0);
      send_word(REQ_TEXT, 8'h00, '0);
      send_word(REQ_TEXT, 8'h00, '0);
      send_word(REQ_TEXT, 8'h00, '0);
      send_word(REQ_APPEND, 8'hFF, '0);
      send_word(REQ_TEXT, 8'h00, '0);
      send_word(REQ_TEXT, 8'h00, '0);
      send_word(REQ_TEXT, 8'hFF, '0);
   endtask

   // The match ends just after the position counter wraps, so its start lies just before the wrap.
   task automatic test_position_wrap();
      send_word(REQ_CLEAR, 8'h00, '0);
      send_word(REQ_APPEND, 8'h11, '0);
      send_word(REQ_APPEND, 8'h22, '0);
      send_word(REQ_RESTART, 8'h00, 32'hFFFF_FFFF);
      send_word(REQ_TEXT, 8'h11, '0);
      send_word(REQ_TEXT, 8'h22, '0);
   endtask

   task automatic test_full_pattern();
      logic [BYTE_W-1:0] pat [MAX_PATTERN];
      send_word(REQ_CLEAR, BYTE_W'($urandom), $urandom);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat[i] = BYTE_W'($urandom);
         send_word(REQ_APPEND, pat[i], $urandom);
      end
      repeat (2) send_word(REQ_APPEND, BYTE_W'($urandom), $urandom);
      send_word(REQ_RESTART, BYTE_W'($urandom), $urandom);
      repeat (2) begin
         for (int i = 0; i < MAX_PATTERN; i++) send_word(REQ_TEXT, pat[i], $urandom);
      end
   endtask

   // Mostly well-formed sequences: clear, a short pattern over a two-byte
   // alphabet, an optional restart, then text that often holds the pattern.
   task automatic run_sequence();
      logic [BYTE_W-1:0] alpha [2];
      logic [BYTE_W-1:0] pat [$];
      logic [BYTE_W-1:0] b;
      logic [POS_W-1:0]  sp;
      int                plen;
      int                tlen;
      int                n;
      int                pick;
      alpha[0] = BYTE_W'($urandom);
      alpha[1] = BYTE_W'($urandom);
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(1, 4))
            send_word(req_code_type'($urandom_range(3)), BYTE_W'($urandom), $urandom);
         return;
      end
      send_word(REQ_CLEAR, BYTE_W'($urandom), $urandom);
      plen = ($urandom_range(99) < 5) ? $urandom_range(30, 34) : $urandom_range(1, 4);
      for (int i = 0; i < plen; i++) begin
         b = ($urandom_range(9) == 0) ? BYTE_W'($urandom) : alpha[$urandom_range(1)];
         send_word(REQ_APPEND, b, $urandom);
         if (pat.size() < MAX_PATTERN) pat.push_back(b);
      end
      if ($urandom_range(99) < 30) begin
         case ($urandom_range(2))
            0: sp = $urandom;
            1: sp = 32'hFFFF_FFFF - $urandom_range(40);
            default: sp = $urandom_range(100);
         endcase
         send_word(REQ_RESTART, BYTE_W'($urandom), sp);
      end
      tlen = $urandom_range(8, 40);
      n = 0;
      while (n < tlen) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            foreach (pat[i]) send_word(REQ_TEXT, pat[i], $urandom);
            n += pat.size();
         end else if (pick < 28) begin
            b = alpha[$urandom_range(1)];
            send_word(REQ_APPEND, b, $urandom);
            if (pat.size() < MAX_PATTERN) pat.push_back(b);
            n++;
         end else if (pick < 36) begin
            send_word(REQ_TEXT, BYTE_W'($urandom), $urandom);
            n++;
         end else begin
            send_word(REQ_TEXT, alpha[$urandom_range(1)], $urandom);
            n++;
         end
      end
   endtask

   task automatic test_random_traffic(int unsigned words);
      int unsigned target;
      target = sent_count + words;
      while (sent_count < target) run_sequence();
   endtask

   task automatic test_drain_pause();
      test_random_traffic(60);
      wait_all_reported();
      test_random_traffic(60);
   endtask

   task automatic test_back_to_back();
      no_gaps = 1'b1;
      test_random_traffic(200);
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pattern();
      test_two_byte_match();
      test_overlap_extremes();
      test_position_wrap();
      test_full_pattern();
      test_random_traffic(250);
      test_drain_pause();
      test_back_to_back();
      test_random_traffic(265);
      wait_all_reported();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && match_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
